### sv/pcvr_pkg.sv
`timescale 1ns / 1ps

package pcvr_pkg;

    // Default component format (signed Q10.10)
    localparam int COMPONENT_WIDTH_DEF = 21;
    localparam int FRACTION_BITS_DEF   = 10;

    // Fixed port widths
    localparam int PACK_W    = 63;
    localparam int IM_W      = 24;
    localparam int TOT_W     = IM_W + 1;
    localparam int REST_W    = 17;
    localparam int TS_W      = 16;
    localparam int CFG_IDX_W = 2;

    // Q1.16 restitution and Q0.16 time-step coefficients drop 16 bits after a product
    localparam int RND_SHIFT = 16;

    // Configuration registers
    localparam logic [CFG_IDX_W-1:0] REG_RESTITUTION = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TIME_STEP   = 2'd1;
    localparam logic [REST_W-1:0]    REST_RESET      = 17'd65536;
    localparam logic [TS_W-1:0]      TS_RESET        = 16'd1092;

    // Result status codes
    localparam logic [1:0] ST_OK  = 2'd0;
    localparam logic [1:0] ST_SEP = 2'd1;
    localparam logic [1:0] ST_IMM = 2'd2;

    // Depth of the queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // Per-contact control that travels with the item
    typedef struct packed {
        logic [1:0] status;
        logic       two;
    } t_ctl;

endpackage

### sv/particle_contact_velocity_resolver.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake            Payload
// config    in         i_cfg_we             i_cfg_idx, i_cfg_data
// contact   in         i_push / o_full      vel_a, vel_b, acc_a, acc_b, normal, masses
// result    out        o_empty / i_pop      new_vel_a, new_vel_b, status
//
// One contact enters per cycle and one result leaves per cycle when nothing stalls.
// The path runs through the front's two stages, a queue slot, and the back, whose restoring
// dividers produce one quotient bit per stage.
// Reset clears valid bits and queue pointers and loads the registers' reset values.
// A result held in the output slot stalls the back; the front keeps filling the queue
// and raises o_full once the queue is full and its last stage holds an item.

module particle_contact_velocity_resolver #(
    parameter int COMPONENT_WIDTH = pcvr_pkg::COMPONENT_WIDTH_DEF,
    parameter int FRACTION_BITS   = pcvr_pkg::FRACTION_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [pcvr_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [pcvr_pkg::REST_W-1:0]    i_cfg_data,
    input  logic                           i_push,
    output logic                           o_full,
    input  logic [pcvr_pkg::PACK_W-1:0]    i_vel_a,
    input  logic [pcvr_pkg::PACK_W-1:0]    i_vel_b,
    input  logic [pcvr_pkg::PACK_W-1:0]    i_acc_a,
    input  logic [pcvr_pkg::PACK_W-1:0]    i_acc_b,
    input  logic [pcvr_pkg::PACK_W-1:0]    i_contact_normal,
    input  logic [pcvr_pkg::IM_W-1:0]      i_inv_mass_a,
    input  logic [pcvr_pkg::IM_W-1:0]      i_inv_mass_b,
    input  logic                           i_has_second,
    output logic                           o_empty,
    input  logic                           i_pop,
    output logic [pcvr_pkg::PACK_W-1:0]    o_new_vel_a,
    output logic [pcvr_pkg::PACK_W-1:0]    o_new_vel_b,
    output logic [1:0]                     o_status
);
    import pcvr_pkg::*;

    localparam int CW = COMPONENT_WIDTH;
    localparam int VW = 3 * CW;
    localparam int SW = 2 * CW + 3;
    localparam int QDW = 3 * VW + 2 * SW + 2 * IM_W + TOT_W + 3;

    logic [REST_W-1:0] r_restitution;
    logic [TS_W-1:0]   r_time_step;

    logic                 f_push, q_full, q_empty, q_pop;
    logic [VW-1:0]        f_va, f_vb, f_n, b_va, b_vb, b_n;
    logic signed [SW-1:0] f_sep, f_accd, b_sep, b_accd;
    logic [IM_W-1:0]      f_ima, f_imb, b_ima, b_imb;
    logic [TOT_W-1:0]     f_total, b_total;
    t_ctl                 f_ctl, b_ctl;
    logic [QDW-1:0]       q_in, q_out;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_restitution <= REST_RESET;
            r_time_step   <= TS_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_RESTITUTION: r_restitution <= i_cfg_data;
                REG_TIME_STEP:   r_time_step   <= i_cfg_data[TS_W-1:0];
                default: ;
            endcase
        end
    end

    pcvr_front #(.COMPONENT_WIDTH(CW)) u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_push           (i_push),
        .o_full           (o_full),
        .i_vel_a          (i_vel_a),
        .i_vel_b          (i_vel_b),
        .i_acc_a          (i_acc_a),
        .i_acc_b          (i_acc_b),
        .i_contact_normal (i_contact_normal),
        .i_inv_mass_a     (i_inv_mass_a),
        .i_inv_mass_b     (i_inv_mass_b),
        .i_has_second     (i_has_second),
        .o_q_push         (f_push),
        .i_q_full         (q_full),
        .o_va             (f_va),
        .o_vb             (f_vb),
        .o_n              (f_n),
        .o_sep            (f_sep),
        .o_accd           (f_accd),
        .o_ima            (f_ima),
        .o_imb            (f_imb),
        .o_total          (f_total),
        .o_ctl            (f_ctl)
    );

    // classified items between front and back
    assign q_in = {f_ctl, f_total, f_imb, f_ima, f_accd, f_sep, f_n, f_vb, f_va};
    assign {b_ctl, b_total, b_imb, b_ima, b_accd, b_sep, b_n, b_vb, b_va} = q_out;

    pcvr_queue #(.WIDTH(QDW), .DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_data  (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_data  (q_out),
        .o_empty (q_empty)
    );

    pcvr_back #(.COMPONENT_WIDTH(CW), .FRACTION_BITS(FRACTION_BITS)) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_restitution (r_restitution),
        .i_time_step   (r_time_step),
        .i_q_empty     (q_empty),
        .o_q_pop       (q_pop),
        .i_va          (b_va),
        .i_vb          (b_vb),
        .i_n           (b_n),
        .i_sep         (b_sep),
        .i_accd        (b_accd),
        .i_ima         (b_ima),
        .i_imb         (b_imb),
        .i_total       (b_total),
        .i_ctl         (b_ctl),
        .i_pop         (i_pop),
        .o_empty       (o_empty),
        .o_new_vel_a   (o_new_vel_a),
        .o_new_vel_b   (o_new_vel_b),
        .o_status      (o_status)
    );

    // no result survives reset
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> o_empty)
        else $error("result pending after reset");

    // front is free after reset
    a_reset_not_full: assert property (@(posedge i_clk) !i_rst_n |=> !o_full)
        else $error("full asserted after reset");

    // only defined status codes are offered
    a_status_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_empty |-> (o_status == ST_OK || o_status == ST_SEP || o_status == ST_IMM))
        else $error("undefined status code on result");

endmodule

### sv/pcvr_front.sv
`timescale 1ns / 1ps

module pcvr_front #(
    parameter int COMPONENT_WIDTH = pcvr_pkg::COMPONENT_WIDTH_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_push,
    output logic                                 o_full,
    input  logic [pcvr_pkg::PACK_W-1:0]          i_vel_a,
    input  logic [pcvr_pkg::PACK_W-1:0]          i_vel_b,
    input  logic [pcvr_pkg::PACK_W-1:0]          i_acc_a,
    input  logic [pcvr_pkg::PACK_W-1:0]          i_acc_b,
    input  logic [pcvr_pkg::PACK_W-1:0]          i_contact_normal,
    input  logic [pcvr_pkg::IM_W-1:0]            i_inv_mass_a,
    input  logic [pcvr_pkg::IM_W-1:0]            i_inv_mass_b,
    input  logic                                 i_has_second,
    output logic                                 o_q_push,
    input  logic                                 i_q_full,
    output logic [3*COMPONENT_WIDTH-1:0]         o_va,
    output logic [3*COMPONENT_WIDTH-1:0]         o_vb,
    output logic [3*COMPONENT_WIDTH-1:0]         o_n,
    output logic signed [2*COMPONENT_WIDTH+2:0]  o_sep,
    output logic signed [2*COMPONENT_WIDTH+2:0]  o_accd,
    output logic [pcvr_pkg::IM_W-1:0]            o_ima,
    output logic [pcvr_pkg::IM_W-1:0]            o_imb,
    output logic [pcvr_pkg::TOT_W-1:0]           o_total,
    output pcvr_pkg::t_ctl                       o_ctl
);
    import pcvr_pkg::*;

    localparam int CW = COMPONENT_WIDTH;
    localparam int VW = 3 * CW;
    localparam int DW = CW + 1;
    localparam int PW = 2 * CW + 1;
    localparam int SW = 2 * CW + 3;

    logic f_en;

    // stage 1 registers
    logic                 r1_v;
    logic [VW-1:0]        r1_va, r1_vb, r1_n;
    logic [IM_W-1:0]      r1_ima, r1_imb;
    logic                 r1_two;
    logic signed [PW-1:0] r1_pv [3];
    logic signed [PW-1:0] r1_pa [3];

    // stage 2 registers
    logic                 r2_v;
    logic [VW-1:0]        r2_va, r2_vb, r2_n;
    logic [IM_W-1:0]      r2_ima, r2_imb;
    logic                 r2_two;
    logic signed [SW-1:0] r2_sep, r2_accd;

    logic signed [PW-1:0] pv [3];
    logic signed [PW-1:0] pa [3];
    logic [TOT_W-1:0]     total;

    // front moves unless its last stage is blocked by the queue
    assign f_en     = !r2_v || !i_q_full;
    assign o_full   = !f_en;
    assign o_q_push = r2_v && !i_q_full;

    // per-component differences (A alone without a second body) and products with the normal
    always_comb begin
        logic signed [CW-1:0] cva, cvb, caa, cab, cn;
        logic signed [DW-1:0] dv, da;
        for (int c = 0; c < 3; c++) begin
            cva = i_vel_a[c*CW +: CW];
            cvb = i_vel_b[c*CW +: CW];
            caa = i_acc_a[c*CW +: CW];
            cab = i_acc_b[c*CW +: CW];
            cn  = i_contact_normal[c*CW +: CW];
            dv  = i_has_second ? (DW'(cva) - DW'(cvb)) : DW'(cva);
            da  = i_has_second ? (DW'(caa) - DW'(cab)) : DW'(caa);
            pv[c] = PW'(dv) * PW'(cn);
            pa[c] = PW'(da) * PW'(cn);
        end
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
        end else if (f_en) begin
            r1_v <= i_push;
            r2_v <= r1_v;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (f_en) begin
            r1_va  <= i_vel_a[VW-1:0];
            r1_vb  <= i_vel_b[VW-1:0];
            r1_n   <= i_contact_normal[VW-1:0];
            r1_ima <= i_inv_mass_a;
            r1_imb <= i_inv_mass_b;
            r1_two <= i_has_second;
            for (int c = 0; c < 3; c++) begin
                r1_pv[c] <= pv[c];
                r1_pa[c] <= pa[c];
            end
            r2_va   <= r1_va;
            r2_vb   <= r1_vb;
            r2_n    <= r1_n;
            r2_ima  <= r1_ima;
            r2_imb  <= r1_imb;
            r2_two  <= r1_two;
            r2_sep  <= SW'(r1_pv[0]) + SW'(r1_pv[1]) + SW'(r1_pv[2]);
            r2_accd <= SW'(r1_pa[0]) + SW'(r1_pa[1]) + SW'(r1_pa[2]);
        end
    end

    // classify: separating first, then immovable
    assign total = TOT_W'(r2_ima) + (r2_two ? TOT_W'(r2_imb) : TOT_W'(0));

    always_comb begin
        o_ctl.two = r2_two;
        if (r2_sep > 0) begin
            o_ctl.status = ST_SEP;
        end else if (total == '0) begin
            o_ctl.status = ST_IMM;
        end else begin
            o_ctl.status = ST_OK;
        end
    end

    assign o_va    = r2_va;
    assign o_vb    = r2_vb;
    assign o_n     = r2_n;
    assign o_sep   = r2_sep;
    assign o_accd  = r2_accd;
    assign o_ima   = r2_ima;
    assign o_imb   = r2_two ? r2_imb : '0;
    assign o_total = total;

endmodule

### sv/pcvr_queue.sv
`timescale 1ns / 1ps

module pcvr_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = pcvr_pkg::QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);
    import pcvr_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNTW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr, r_rd;
    logic [CNTW-1:0]  r_cnt;
    logic             do_push, do_pop;

    assign o_full  = (r_cnt == CNTW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

### sv/pcvr_div.sv
`timescale 1ns / 1ps

module pcvr_div #(
    parameter int QW = 45,
    parameter int IW = pcvr_pkg::IM_W
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [QW+IW-1:0] i_num,
    input  logic [IW:0]      i_den,
    output logic [QW-1:0]    o_quo
);
    import pcvr_pkg::*;

    // restoring division, one quotient bit per stage;
    // the quotient is known to fit in QW bits
    localparam int TW = IW + 1;

    logic [TW-1:0] r_rem [QW-1];
    logic [TW-1:0] r_den [QW-1];
    logic [QW-1:0] r_num [QW-1];
    logic [QW-1:0] r_quo [QW];

    for (genvar k = 0; k < QW; k++) begin : g_stage
        logic [TW-1:0] rem_in, den_in;
        logic [QW-1:0] num_in, quo_in;
        logic [TW:0]   trial;
        logic          ge;

        if (k == 0) begin : g_first
            assign rem_in = TW'(i_num[QW+IW-1:QW]);
            assign num_in = i_num[QW-1:0];
            assign quo_in = '0;
            assign den_in = i_den;
        end else begin : g_next
            assign rem_in = r_rem[k-1];
            assign num_in = r_num[k-1];
            assign quo_in = r_quo[k-1];
            assign den_in = r_den[k-1];
        end

        assign trial = {rem_in, num_in[QW-1]};
        assign ge    = (trial >= {1'b0, den_in});

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_quo[k] <= {quo_in[QW-2:0], ge};
            end
        end

        if (k < QW - 1) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[k] <= ge ? TW'(trial - {1'b0, den_in}) : TW'(trial);
                    r_num[k] <= {num_in[QW-2:0], 1'b0};
                    r_den[k] <= den_in;
                end
            end
        end
    end

    assign o_quo = r_quo[QW-1];

endmodule

### sv/pcvr_back.sv
`timescale 1ns / 1ps

module pcvr_back #(
    parameter int COMPONENT_WIDTH = pcvr_pkg::COMPONENT_WIDTH_DEF,
    parameter int FRACTION_BITS   = pcvr_pkg::FRACTION_BITS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic [pcvr_pkg::REST_W-1:0]          i_restitution,
    input  logic [pcvr_pkg::TS_W-1:0]            i_time_step,
    input  logic                                 i_q_empty,
    output logic                                 o_q_pop,
    input  logic [3*COMPONENT_WIDTH-1:0]         i_va,
    input  logic [3*COMPONENT_WIDTH-1:0]         i_vb,
    input  logic [3*COMPONENT_WIDTH-1:0]         i_n,
    input  logic signed [2*COMPONENT_WIDTH+2:0]  i_sep,
    input  logic signed [2*COMPONENT_WIDTH+2:0]  i_accd,
    input  logic [pcvr_pkg::IM_W-1:0]            i_ima,
    input  logic [pcvr_pkg::IM_W-1:0]            i_imb,
    input  logic [pcvr_pkg::TOT_W-1:0]           i_total,
    input  pcvr_pkg::t_ctl                       i_ctl,
    input  logic                                 i_pop,
    output logic                                 o_empty,
    output logic [pcvr_pkg::PACK_W-1:0]          o_new_vel_a,
    output logic [pcvr_pkg::PACK_W-1:0]          o_new_vel_b,
    output logic [1:0]                           o_status
);
    import pcvr_pkg::*;

    localparam int CW   = COMPONENT_WIDTH;
    localparam int FB   = FRACTION_BITS;
    localparam int VW   = 3 * CW;
    localparam int SW   = 2 * CW + 3;
    localparam int TGW  = SW + 2;
    localparam int DLW  = SW;
    localparam int LO   = DLW / 2;
    localparam int HI   = DLW - LO;
    localparam int NW   = DLW + IM_W;
    localparam int SFW  = DLW + 1 - FB;
    localparam int PRW  = CW + SFW + 1;
    localparam int M1W  = SW + REST_W + 2;
    localparam int M2W  = SW + TS_W + 1;
    localparam int M3W  = SW + REST_W + 1;
    localparam int BW   = 3 * VW + 3;
    localparam int L    = DLW + 7;
    localparam int IX_B6 = DLW + 5;
    localparam int HALF_FB = 1 << (FB - 1);
    localparam logic signed [63:0] VMAX = (64'sd1 <<< (CW - 1)) - 64'sd1;
    localparam logic signed [63:0] VMIN = -(64'sd1 <<< (CW - 1));

    // round to nearest, ties away from zero
    function automatic logic signed [63:0] rnd(input logic signed [63:0] v, input int s);
        logic signed [63:0] h;
        h = 64'sd1 <<< (s - 1);
        return (v + h - ((v < 0) ? 64'sd1 : 64'sd0)) >>> s;
    endfunction

    function automatic logic [CW-1:0] sat(input logic signed [63:0] v);
        logic signed [63:0] t;
        t = v;
        if (t > VMAX) t = VMAX;
        if (t < VMIN) t = VMIN;
        return t[CW-1:0];
    endfunction

    logic b_en;
    logic [L-1:0] r_v;
    logic [BW-1:0] r_base [L];
    logic r_out_v;

    // stage registers
    logic signed [TGW-1:0] r1_tgt, r2_tgt, r2_ra;
    logic signed [SW-1:0]  r1_acc, r1_sep, r2_sep;
    logic                  r2_neg;
    logic [IM_W-1:0]       r1_ima, r1_imb, r2_ima, r2_imb, r3_ima, r3_imb;
    logic [TOT_W-1:0]      r1_tot, r2_tot, r3_tot, r4_tot, r5_tot;
    logic [DLW-1:0]        r3_delta;
    logic [LO+IM_W-1:0]    r4_pa_lo, r4_pb_lo;
    logic [HI+IM_W-1:0]    r4_pa_hi, r4_pb_hi;
    logic [NW-1:0]         r5_num_a, r5_num_b;
    logic [DLW-1:0]        quo_a, quo_b;
    logic [SFW-1:0]        r6_sf_a, r6_sf_b;
    logic signed [PRW-1:0] r7_pr_a [3];
    logic signed [PRW-1:0] r7_pr_b [3];
    logic [PACK_W-1:0]     r_out_a, r_out_b;
    logic [1:0]            r_out_st;

    logic signed [REST_W:0] rs;
    logic signed [TS_W:0]   ts;
    logic signed [SW:0]     nsep;
    logic signed [M1W-1:0]  m1;
    logic signed [M2W-1:0]  m2;
    logic signed [M3W-1:0]  m3;
    logic signed [63:0]     w1_t, w1_a, w2_r;
    logic signed [TGW:0]    t3;
    logic signed [TGW+1:0]  d3;
    logic [VW-1:0]          upd_a, upd_b;
    logic [BW-1:0]          base6, base8;
    t_ctl                   ctl8;

    // back pipeline moves while the output slot is free or being taken
    assign b_en    = !r_out_v || i_pop;
    assign o_q_pop = b_en && !i_q_empty;

    // restitution and acceleration products
    assign rs   = signed'({1'b0, i_restitution});
    assign ts   = signed'({1'b0, i_time_step});
    assign nsep = -((SW + 1)'(i_sep));
    assign m1   = M1W'(nsep) * M1W'(rs);
    assign m2   = M2W'(i_accd) * M2W'(ts);
    assign w1_t = rnd(64'(m1), RND_SHIFT);
    assign w1_a = rnd(64'(m2), RND_SHIFT);
    assign m3   = M3W'(rs) * M3W'(r1_acc);
    assign w2_r = rnd(64'(m3), RND_SHIFT);

    // target with acceleration term, clamped, then the velocity change
    always_comb begin
        t3 = (TGW + 1)'(r2_tgt) + (r2_neg ? (TGW + 1)'(r2_ra) : (TGW + 1)'(0));
        if (r2_neg && t3[TGW]) begin
            t3 = '0;
        end
        d3 = (TGW + 2)'(t3) - (TGW + 2)'(r2_sep);
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v     <= '0;
            r_out_v <= 1'b0;
        end else if (b_en) begin
            r_v     <= {r_v[L-2:0], o_q_pop};
            r_out_v <= r_v[L-1];
        end
    end

    // item payload that rides alongside the arithmetic
    always_ff @(posedge i_clk) begin
        if (b_en) begin
            r_base[0] <= {i_ctl, i_n, i_vb, i_va};
            for (int k = 1; k < L; k++) begin
                r_base[k] <= r_base[k-1];
            end
        end
    end

    // arithmetic stages up to the dividers
    always_ff @(posedge i_clk) begin
        if (b_en) begin
            r1_tgt <= w1_t[TGW-1:0];
            r1_acc <= w1_a[SW-1:0];
            r1_sep <= i_sep;
            r1_ima <= i_ima;
            r1_imb <= i_imb;
            r1_tot <= i_total;

            r2_ra  <= w2_r[TGW-1:0];
            r2_neg <= r1_acc[SW-1];
            r2_tgt <= r1_tgt;
            r2_sep <= r1_sep;
            r2_ima <= r1_ima;
            r2_imb <= r1_imb;
            r2_tot <= r1_tot;

            r3_delta <= d3[DLW-1:0];
            r3_ima   <= r2_ima;
            r3_imb   <= r2_imb;
            r3_tot   <= r2_tot;

            r4_pa_lo <= (LO + IM_W)'(r3_delta[LO-1:0]) * (LO + IM_W)'(r3_ima);
            r4_pa_hi <= (HI + IM_W)'(r3_delta[DLW-1:LO]) * (HI + IM_W)'(r3_ima);
            r4_pb_lo <= (LO + IM_W)'(r3_delta[LO-1:0]) * (LO + IM_W)'(r3_imb);
            r4_pb_hi <= (HI + IM_W)'(r3_delta[DLW-1:LO]) * (HI + IM_W)'(r3_imb);
            r4_tot   <= r3_tot;

            r5_num_a <= (NW'(r4_pa_hi) << LO) + NW'(r4_pa_lo);
            r5_num_b <= (NW'(r4_pb_hi) << LO) + NW'(r4_pb_lo);
            r5_tot   <= r4_tot;
        end
    end

    // shares delta * im / total
    pcvr_div #(.QW(DLW), .IW(IM_W)) u_div_a (
        .i_clk (i_clk),
        .i_en  (b_en),
        .i_num (r5_num_a),
        .i_den (r5_tot),
        .o_quo (quo_a)
    );

    pcvr_div #(.QW(DLW), .IW(IM_W)) u_div_b (
        .i_clk (i_clk),
        .i_en  (b_en),
        .i_num (r5_num_b),
        .i_den (r5_tot),
        .o_quo (quo_b)
    );

    assign base6 = r_base[IX_B6];
    assign base8 = r_base[L-1];
    assign ctl8  = t_ctl'(base8[BW-1 -: 3]);

    // round shares, then scale by the normal
    always_ff @(posedge i_clk) begin
        if (b_en) begin
            r6_sf_a <= SFW'(((DLW + 1)'(quo_a) + (DLW + 1)'(HALF_FB)) >> FB);
            r6_sf_b <= SFW'(((DLW + 1)'(quo_b) + (DLW + 1)'(HALF_FB)) >> FB);
            for (int c = 0; c < 3; c++) begin
                r7_pr_a[c] <= PRW'(signed'(base6[2*VW + c*CW +: CW]))
                            * PRW'(signed'({1'b0, r6_sf_a}));
                r7_pr_b[c] <= PRW'(signed'(base6[2*VW + c*CW +: CW]))
                            * PRW'(signed'({1'b0, r6_sf_b}));
            end
        end
    end

    // apply and saturate
    always_comb begin
        logic signed [63:0] va, vb, da, db;
        for (int c = 0; c < 3; c++) begin
            va = 64'(signed'(base8[c*CW +: CW]));
            vb = 64'(signed'(base8[VW + c*CW +: CW]));
            da = rnd(64'(r7_pr_a[c]), FB);
            db = rnd(64'(r7_pr_b[c]), FB);
            upd_a[c*CW +: CW] = sat(va + da);
            upd_b[c*CW +: CW] = sat(vb - db);
        end
    end

    // output slot
    always_ff @(posedge i_clk) begin
        if (b_en) begin
            r_out_st <= ctl8.status;
            if (ctl8.status == ST_OK) begin
                r_out_a <= PACK_W'(upd_a);
                r_out_b <= ctl8.two ? PACK_W'(upd_b) : PACK_W'(base8[2*VW-1:VW]);
            end else begin
                r_out_a <= PACK_W'(base8[VW-1:0]);
                r_out_b <= PACK_W'(base8[2*VW-1:VW]);
            end
        end
    end

    assign o_empty     = !r_out_v;
    assign o_new_vel_a = r_out_a;
    assign o_new_vel_b = r_out_b;
    assign o_status    = r_out_st;

endmodule
